// ===== rtl/core/vde_pkg.sv =====
// Shared types and constants of the vector distance engine.
package vde_pkg;

  localparam int ELEM_BITS    = 16;
  localparam int ACC_BITS     = 48;
  localparam int LEN_BITS     = 10;
  localparam int CNT_BITS     = 16;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_BITS     = 16;
  localparam int METRIC_BITS  = 2;
  localparam int PROD_BITS    = 2 * ELEM_BITS + 2;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);

  // Q18.30 representation of one.
  localparam logic [ACC_BITS-1:0] ONE_Q30 = ACC_BITS'(1) << 30;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_METRIC        = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_VECTOR_LENGTH = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BATCH_SIZE    = 2'd2;

  // Metric register codes; the unused code behaves as cosine.
  localparam logic [METRIC_BITS-1:0] METRIC_COSINE = 2'd0;
  localparam logic [METRIC_BITS-1:0] METRIC_L2     = 2'd1;
  localparam logic [METRIC_BITS-1:0] METRIC_DOT    = 2'd2;

  // Register reset values.
  localparam logic [METRIC_BITS-1:0] METRIC_RESET = METRIC_COSINE;
  localparam logic [LEN_BITS-1:0]    LENGTH_RESET = 10'd384;
  localparam logic [CNT_BITS-1:0]    BATCH_RESET  = 16'd1;

  // Operation decided by the front for each pair.
  typedef enum logic [1:0] {
    OP_COS,
    OP_L2,
    OP_DOT
  } op_t;

  typedef struct packed {
    logic signed [ELEM_BITS-1:0] query_elem;
    logic signed [ELEM_BITS-1:0] cand_elem;
  } in_item_t;

  typedef struct packed {
    logic signed [ACC_BITS-1:0] distance;
    logic [CNT_BITS-1:0]        candidate_index;
    logic                       last_in_batch;
  } out_item_t;

  // One classified pair as it waits between front and back.
  typedef struct packed {
    logic signed [ELEM_BITS-1:0] query_elem;
    logic signed [ELEM_BITS-1:0] cand_elem;
    op_t                         op;
    logic                        vec_end;
    logic [CNT_BITS-1:0]         cand_index;
    logic                        last;
  } entry_t;

endpackage

// ===== rtl/core/vector_distance_engine.sv =====
// Top level of the streaming vector distance engine.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   in_data   (query_elem, cand_elem)
//   out      output     out_valid / out_ready out_data  (distance, index, last)
//   cfg      input      cfg_wr_en             cfg_index, cfg_data
//
// One element pair is taken per cycle while the queue has room; a four-entry
// queue sits between the classifying front and the multiply-accumulate back.
// A distance passes through the queue and the multiply, accumulate and output
// register stages after the vector's last pair is transferred.
// Reset is synchronous: counters, accumulator and queue are cleared by it.
// An untaken result stalls the back; the front keeps taking pairs until the
// queue is full.
module vector_distance_engine (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [vde_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [vde_pkg::CFG_BITS-1:0]     cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  vde_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output vde_pkg::out_item_t               out_data
);
  import vde_pkg::*;

  logic   q_full;
  logic   push;
  entry_t push_data;
  logic   pop;
  logic   head_valid;
  entry_t head_data;

  vde_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  vde_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  vde_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// ===== rtl/core/vde_front.sv =====
// Front end: configuration registers, input transfer and pair classification.
module vde_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [vde_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [vde_pkg::CFG_BITS-1:0]      cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  vde_pkg::in_item_t                 in_data,
  input  logic                              q_full,
  output logic                              push,
  output vde_pkg::entry_t                   push_data
);
  import vde_pkg::*;

  logic [METRIC_BITS-1:0] metric;
  logic [LEN_BITS-1:0]    vector_length;
  logic [CNT_BITS-1:0]    batch_size;
  logic [LEN_BITS-1:0]    element_count;
  logic [CNT_BITS-1:0]    candidate_count;

  logic [LEN_BITS-1:0]    len_eff;
  logic [CNT_BITS-1:0]    bsz_eff;
  logic [LEN_BITS-1:0]    elem_inc;
  logic [CNT_BITS:0]      cand_inc;
  logic                   vec_end;
  logic                   last;
  op_t                    op;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      metric        <= METRIC_RESET;
      vector_length <= LENGTH_RESET;
      batch_size    <= BATCH_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_METRIC:        metric        <= cfg_data[METRIC_BITS-1:0];
        CFG_VECTOR_LENGTH: vector_length <= cfg_data[LEN_BITS-1:0];
        CFG_BATCH_SIZE:    batch_size    <= cfg_data[CNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Classify the pair: vector end, candidate index, batch end, operation
  always_comb begin
    len_eff  = (vector_length == '0) ? LEN_BITS'(1) : vector_length;
    bsz_eff  = (batch_size == '0) ? CNT_BITS'(1) : batch_size;
    elem_inc = element_count + LEN_BITS'(1);
    vec_end  = (elem_inc >= len_eff);
    cand_inc = {1'b0, candidate_count} + (CNT_BITS+1)'(1);
    last     = (cand_inc >= {1'b0, bsz_eff});
    unique case (metric)
      METRIC_L2:  op = OP_L2;
      METRIC_DOT: op = OP_DOT;
      default:    op = OP_COS;
    endcase
  end

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  always_comb begin
    push_data.query_elem = in_data.query_elem;
    push_data.cand_elem  = in_data.cand_elem;
    push_data.op         = op;
    push_data.vec_end    = vec_end;
    push_data.cand_index = candidate_count;
    push_data.last       = last;
  end

  // Advance element and candidate counters on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      element_count   <= '0;
      candidate_count <= '0;
    end else if (push) begin
      element_count <= vec_end ? '0 : elem_inc;
      if (vec_end) begin
        candidate_count <= last ? '0 : cand_inc[CNT_BITS-1:0];
      end
    end
  end

endmodule

// ===== rtl/core/vde_queue.sv =====
// Small register queue of classified pairs between front and back.
module vde_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  vde_pkg::entry_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output vde_pkg::entry_t head_data
);
  import vde_pkg::*;

  entry_t               slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   count;
  logic                 do_push;
  logic                 do_pop;

  assign full       = (count == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Store incoming entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + QPTR_BITS'(1);
      if (do_pop)  rd_ptr <= rd_ptr + QPTR_BITS'(1);
      count <= count + (QPTR_BITS+1)'(do_push) - (QPTR_BITS+1)'(do_pop);
    end
  end

endmodule

// ===== rtl/core/vde_back.sv =====
// Back end: multiply stage, accumulate stage and distance output register.
module vde_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  vde_pkg::entry_t    head_data,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output vde_pkg::out_item_t out_data
);
  import vde_pkg::*;

  logic                        en;
  logic signed [ELEM_BITS:0]   qa;
  logic signed [ELEM_BITS:0]   cb;
  logic signed [ELEM_BITS:0]   diff;
  logic signed [ELEM_BITS:0]   mx;
  logic signed [ELEM_BITS:0]   my;
  logic signed [PROD_BITS-1:0] prod;

  logic                        s1_valid;
  logic [ACC_BITS-1:0]         s1_term;
  logic                        s1_end;
  op_t                         s1_op;
  logic [CNT_BITS-1:0]         s1_index;
  logic                        s1_last;

  logic [ACC_BITS-1:0]         acc;
  logic [ACC_BITS-1:0]         acc_sum;
  logic                        fin_valid;
  logic [ACC_BITS-1:0]         fin_sum;
  op_t                         fin_op;
  logic [CNT_BITS-1:0]         fin_index;
  logic                        fin_last;
  logic [ACC_BITS-1:0]         dist_value;

  // Stall the whole pipeline only while a result waits untaken
  assign en  = !out_valid || out_ready;
  assign pop = en && head_valid;

  // Share one multiplier: squared difference or plain product
  always_comb begin
    qa   = {head_data.query_elem[ELEM_BITS-1], head_data.query_elem};
    cb   = {head_data.cand_elem[ELEM_BITS-1], head_data.cand_elem};
    diff = qa - cb;
    if (head_data.op == OP_L2) begin
      mx = diff;
      my = diff;
    end else begin
      mx = qa;
      my = cb;
    end
    prod = mx * my;
  end

  // Multiply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_term  <= {{(ACC_BITS-PROD_BITS){prod[PROD_BITS-1]}}, prod};
      s1_end   <= head_data.vec_end;
      s1_op    <= head_data.op;
      s1_index <= head_data.cand_index;
      s1_last  <= head_data.last;
    end
  end

  // Accumulate stage; clear at the end of each vector
  assign acc_sum = acc + s1_term;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      fin_valid <= 1'b0;
    end else if (en) begin
      fin_valid <= s1_valid && s1_end;
      if (s1_valid) begin
        acc <= s1_end ? '0 : acc_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_sum   <= acc_sum;
      fin_op    <= s1_op;
      fin_index <= s1_index;
      fin_last  <= s1_last;
    end
  end

  // Form the distance from the finished sum
  always_comb begin
    unique case (fin_op)
      OP_L2:   dist_value = fin_sum;
      OP_DOT:  dist_value = '0 - fin_sum;
      default: dist_value = ONE_Q30 - fin_sum;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && fin_valid) begin
      out_data.distance        <= dist_value;
      out_data.candidate_index <= fin_index;
      out_data.last_in_batch   <= fin_last;
    end
  end

endmodule

// ===== rtl/core/vde_checker.sv =====
// Port-level checks of the vector distance engine and their binding.
module vde_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input vde_pkg::out_item_t               out_data
);
  import vde_pkg::*;

  logic [CNT_BITS-1:0] exp_index;

  // Track the candidate index the next result must carry
  always_ff @(posedge clk) begin
    if (rst) begin
      exp_index <= '0;
    end else if (out_valid && out_ready) begin
      exp_index <= out_data.last_in_batch ? '0 :
                   out_data.candidate_index + CNT_BITS'(1);
    end
  end

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // Drop any result on reset
  a_reset_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");

  // Queue is empty after reset, so input is taken
  a_reset_ready: assert property (@(posedge clk) rst |=> in_ready)
    else $error("input not ready after reset");

  // Candidate indexes count up within a batch and restart after its last
  a_index_seq: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.candidate_index == exp_index)
    else $error("candidate index out of sequence");

endmodule

bind vector_distance_engine vde_checker u_vde_checker (.*);
